// ===== sv/jds_pkg.sv =====
// Shared types and codes for the job dependency scoreboard.
`default_nettype none
package jds_pkg;

    localparam int FIELD_ID_W  = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Request codes as they arrive on the input word.
    localparam logic [2:0] REQ_ADD    = 3'd0;
    localparam logic [2:0] REQ_REMOVE = 3'd1;
    localparam logic [2:0] REQ_FINISH = 3'd2;
    localparam logic [2:0] REQ_QUERY  = 3'd3;
    localparam logic [2:0] REQ_LIST   = 3'd4;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_FULL      = 2'd2
    } status_t;

    // Classified operation handed from the front end to the back end.
    typedef enum logic [2:0] {
        OP_NOP,
        OP_ADD,
        OP_REMOVE,
        OP_CLEAR,
        OP_QUERY,
        OP_LIST
    } cmd_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LIST
    } state_t;

    typedef struct packed {
        logic [2:0]            req_type;
        logic [FIELD_ID_W-1:0] job_a;
        logic [FIELD_ID_W-1:0] job_b;
        logic                  succeeded;
    } req_t;

    typedef struct packed {
        status_t               status;
        logic                  can_run;
        logic [FIELD_ID_W-1:0] prereq_id;
        logic                  prereq_valid;
        logic                  last;
    } rsp_t;

    typedef struct packed {
        cmd_op_t               op;
        logic [FIELD_ID_W-1:0] id_a;
        logic [FIELD_ID_W-1:0] id_b;
    } cmd_t;

endpackage
`default_nettype wire

// ===== sv/jds_front.sv =====
// Front end: accepts request words and classifies them into table operations.
`default_nettype none
module jds_front #(
    parameter int ID_BITS = 8
) (
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire jds_pkg::req_t req_data,
    output logic               push,
    output jds_pkg::cmd_t      push_cmd,
    input  wire logic          push_ready
);
    import jds_pkg::*;

    localparam int IDW_EXT = (ID_BITS > FIELD_ID_W) ? ID_BITS : FIELD_ID_W;

    logic [IDW_EXT-1:0] a_ext;
    logic [IDW_EXT-1:0] b_ext;
    logic [IDW_EXT-1:0] a_back;
    logic [IDW_EXT-1:0] b_back;
    logic [ID_BITS-1:0] a_trunc;
    logic [ID_BITS-1:0] b_trunc;

    assign req_ready = push_ready;
    assign push      = req_valid && push_ready;

    // Ids are reduced to the table's id width here, so the back end only compares.
    // A finish without success and an unknown code both leave the table alone.
    always_comb
    begin
        a_ext   = IDW_EXT'(req_data.job_a);
        b_ext   = IDW_EXT'(req_data.job_b);
        a_trunc = a_ext[ID_BITS-1:0];
        b_trunc = b_ext[ID_BITS-1:0];
        a_back  = IDW_EXT'(a_trunc);
        b_back  = IDW_EXT'(b_trunc);
        push_cmd.id_a = a_back[FIELD_ID_W-1:0];
        push_cmd.id_b = b_back[FIELD_ID_W-1:0];
        case (req_data.req_type)
            REQ_ADD:    push_cmd.op = OP_ADD;
            REQ_REMOVE: push_cmd.op = OP_REMOVE;
            REQ_FINISH: push_cmd.op = req_data.succeeded ? OP_CLEAR : OP_NOP;
            REQ_QUERY:  push_cmd.op = OP_QUERY;
            REQ_LIST:   push_cmd.op = OP_LIST;
            default:    push_cmd.op = OP_NOP;
        endcase
    end

endmodule
`default_nettype wire

// ===== sv/jds_queue.sv =====
// Short command queue between the front end and the back end.
`default_nettype none
module jds_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire jds_pkg::cmd_t push_cmd,
    output logic               push_ready,
    input  wire logic          pop,
    output jds_pkg::cmd_t      pop_cmd,
    output logic               pop_valid
);
    import jds_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== sv/jds_back.sv =====
// Back end: the pair table, its slot-parallel compares and the result register.
`default_nettype none
module jds_back #(
    parameter int TABLE_DEPTH = 32,
    parameter int ID_BITS     = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    input  wire jds_pkg::cmd_t cmd_in,
    output logic               cmd_pop,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output jds_pkg::rsp_t      rsp_data
);
    import jds_pkg::*;

    localparam int IDW_EXT = (ID_BITS > FIELD_ID_W) ? ID_BITS : FIELD_ID_W;

    state_t                 state_reg;
    state_t                 state_next;
    cmd_t                   cmd_reg;
    logic [TABLE_DEPTH-1:0] slot_valid_reg;
    logic [TABLE_DEPTH-1:0] slot_valid_next;
    logic [ID_BITS-1:0]     dep_id_reg [TABLE_DEPTH];
    logic [ID_BITS-1:0]     pre_id_reg [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] list_mask_reg;
    logic [TABLE_DEPTH-1:0] list_mask_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    rsp_t                   out_word_reg;
    rsp_t                   out_word_next;

    logic [IDW_EXT-1:0]     a_ext;
    logic [IDW_EXT-1:0]     b_ext;
    logic [IDW_EXT-1:0]     pick_ext;
    logic [ID_BITS-1:0]     a_id;
    logic [ID_BITS-1:0]     b_id;
    logic [ID_BITS-1:0]     pick_id;
    logic [TABLE_DEPTH-1:0] dep_hit;
    logic [TABLE_DEPTH-1:0] pre_hit;
    logic [TABLE_DEPTH-1:0] pair_hit;
    logic [TABLE_DEPTH-1:0] free_mask;
    logic [TABLE_DEPTH-1:0] free_oh;
    logic [TABLE_DEPTH-1:0] pair_oh;
    logic [TABLE_DEPTH-1:0] list_oh;
    logic [TABLE_DEPTH-1:0] list_rest;
    logic [TABLE_DEPTH-1:0] write_oh;
    logic                   out_free;
    logic                   out_load;

    assign out_free  = !out_valid_reg || rsp_ready;
    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_word_reg;
    assign cmd_pop   = (state_reg == ST_IDLE) && cmd_valid;

    assign a_ext = IDW_EXT'(cmd_reg.id_a);
    assign b_ext = IDW_EXT'(cmd_reg.id_b);
    assign a_id  = a_ext[ID_BITS-1:0];
    assign b_id  = b_ext[ID_BITS-1:0];

    // Every slot compares against the current command at once.
    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            dep_hit[i]  = slot_valid_reg[i] && (dep_id_reg[i] == a_id);
            pre_hit[i]  = slot_valid_reg[i] && (pre_id_reg[i] == a_id);
            pair_hit[i] = dep_hit[i] && (pre_id_reg[i] == b_id);
        end
    end

    // Isolating the lowest set bit gives the lowest-numbered slot as a one-hot mask.
    assign free_mask = ~slot_valid_reg;
    assign free_oh   = free_mask & (~free_mask + TABLE_DEPTH'(1));
    assign pair_oh   = pair_hit & (~pair_hit + TABLE_DEPTH'(1));
    assign list_oh   = list_mask_reg & (~list_mask_reg + TABLE_DEPTH'(1));
    assign list_rest = list_mask_reg & ~list_oh;

    always_comb
    begin
        pick_id = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (list_oh[i])
            begin
                pick_id = pick_id | pre_id_reg[i];
            end
        end
        pick_ext = IDW_EXT'(pick_id);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = ((cmd_reg.op == OP_LIST) && (|dep_hit)) ? ST_LIST : ST_IDLE;
                end
            end
            ST_LIST:
            begin
                if (out_free && (list_rest == '0))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        list_mask_next  = list_mask_reg;
        write_oh        = '0;
        out_load        = 1'b0;
        out_word_next   = out_word_reg;
        case (state_reg)
            ST_EXEC:
            begin
                if (out_free)
                begin
                    out_load                   = 1'b1;
                    out_word_next              = '0;
                    out_word_next.status       = STATUS_OK;
                    out_word_next.last         = 1'b1;
                    case (cmd_reg.op)
                        OP_ADD:
                        begin
                            if (|free_mask)
                            begin
                                write_oh        = free_oh;
                                slot_valid_next = slot_valid_reg | free_oh;
                            end
                            else
                            begin
                                out_word_next.status = STATUS_FULL;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (|pair_hit)
                            begin
                                slot_valid_next = slot_valid_reg & ~pair_oh;
                            end
                            else
                            begin
                                out_word_next.status = STATUS_NOT_FOUND;
                            end
                        end
                        OP_CLEAR:
                        begin
                            slot_valid_next = slot_valid_reg & ~pre_hit;
                        end
                        OP_QUERY:
                        begin
                            out_word_next.can_run = ~|dep_hit;
                        end
                        OP_LIST:
                        begin
                            // A non-empty list is emitted from the list state instead.
                            if (|dep_hit)
                            begin
                                out_load       = 1'b0;
                                out_word_next  = out_word_reg;
                                list_mask_next = dep_hit;
                            end
                        end
                        default:
                        begin
                            out_word_next.status = STATUS_OK;
                        end
                    endcase
                end
            end
            ST_LIST:
            begin
                if (out_free)
                begin
                    out_load                   = 1'b1;
                    out_word_next              = '0;
                    out_word_next.status       = STATUS_OK;
                    out_word_next.prereq_id    = pick_ext[FIELD_ID_W-1:0];
                    out_word_next.prereq_valid = 1'b1;
                    out_word_next.last         = (list_rest == '0);
                    list_mask_next             = list_rest;
                end
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            slot_valid_reg <= '0;
            list_mask_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            slot_valid_reg <= slot_valid_next;
            list_mask_reg  <= list_mask_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cmd_reg <= cmd_in;
        end
        if (out_load)
        begin
            out_word_reg <= out_word_next;
        end
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (write_oh[i])
            begin
                dep_id_reg[i] <= a_id;
                pre_id_reg[i] <= b_id;
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/job_dependency_scoreboard_top.sv =====
// A result word follows its accepted request word through the queue entry, the
// back end's command register and its result register. The back end takes a new
// command only when idle (pop, then execute); a list yields a word per entry.
// The two-entry command queue lets requests be taken while the back end is busy.
// Reset (rst_n, asynchronous, active low) clears every slot valid bit at once;
// there is no clearing pass and the block takes requests right after reset.
`default_nettype none
module job_dependency_scoreboard_top #(
    parameter int TABLE_DEPTH = 32,
    parameter int ID_BITS     = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire jds_pkg::req_t req_data,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output jds_pkg::rsp_t      rsp_data
);
    import jds_pkg::*;

    logic push;
    logic push_ready;
    cmd_t push_cmd;
    logic pop;
    logic pop_valid;
    cmd_t pop_cmd;

    jds_front #(
        .ID_BITS(ID_BITS)
    ) u_front (
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .push      (push),
        .push_cmd  (push_cmd),
        .push_ready(push_ready)
    );

    jds_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .push_ready(push_ready),
        .pop       (pop),
        .pop_cmd   (pop_cmd),
        .pop_valid (pop_valid)
    );

    jds_back #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .ID_BITS    (ID_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(pop_valid),
        .cmd_in   (pop_cmd),
        .cmd_pop  (pop),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp_data (rsp_data)
    );

    // Only a listed entry can be followed by more words of the same request.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.last |-> rsp_data.prereq_valid)
        else $error("non-final result word without a listed prerequisite");

    // A listed entry always carries an ok status and no can-run flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.prereq_valid |-> rsp_data.status == STATUS_OK && !rsp_data.can_run)
        else $error("listed prerequisite word has stray status or can-run");

    // Error statuses come only from single-word add and remove requests.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status != STATUS_OK |-> rsp_data.last && !rsp_data.prereq_valid)
        else $error("error status on a list word");

    // A request is only taken when the queue has room.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |-> push)
        else $error("accepted request word was not queued");

endmodule
`default_nettype wire
